// ===== design/websocket_frame_header_parser_top_defines.svh =====
// assertion macros shared by the parser design files
`ifndef WEBSOCKET_FRAME_HEADER_PARSER_TOP_DEFINES_SVH
`define WEBSOCKET_FRAME_HEADER_PARSER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define WSFHP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wsfhp same-cycle check failed");

// next-cycle implication, checked outside reset
`define WSFHP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wsfhp next-cycle check failed");

`endif

// ===== design/wsfhp_pkg.sv =====
// types and constants of the websocket frame header parser
`timescale 1ns / 1ps

package wsfhp_pkg;

    // header byte fields
    localparam logic [6:0] LEN_EXT16   = 7'd126;
    localparam logic [6:0] LEN_EXT64   = 7'd127;
    localparam logic [3:0] HDR_BASE    = 4'd2;
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;
    localparam logic [3:0] HDR_MAX     = 4'd14;

    // result queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_KEY     = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_DONE    = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        ST_COMPLETE = 2'd0,
        ST_SHORT    = 2'd1,
        ST_LEN_WIDE = 2'd2
    } t_status;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_SUMMARY = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  payload_byte;
        t_status     status;
        logic        fin;
        logic [3:0]  opcode;
        logic        masked;
        logic [31:0] data_len;
        logic [31:0] mask_key;
        logic [3:0]  header_len;
        logic [32:0] total_len;
    } t_result;

    // words pushed into the result queue by one accepted byte
    typedef struct packed {
        logic push_one;
        logic push_two;
    } t_push;

endpackage

// ===== design/wsfhp_if.sv =====
// valid/ready channels for received bytes and parser results
`timescale 1ns / 1ps

interface wsfhp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wsfhp_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  payload_byte;
    logic [1:0]  status;
    logic        fin;
    logic [3:0]  opcode;
    logic        masked;
    logic [31:0] data_len;
    logic [31:0] mask_key;
    logic [3:0]  header_len;
    logic [32:0] total_len;

    modport source (
        output valid, output kind, output payload_byte, output status, output fin,
        output opcode, output masked, output data_len, output mask_key,
        output header_len, output total_len, input ready
    );
    modport sink (
        input valid, input kind, input payload_byte, input status, input fin,
        input opcode, input masked, input data_len, input mask_key,
        input header_len, input total_len, output ready
    );
endinterface

// ===== design/websocket_frame_header_parser_top.sv =====
// a word for an accepted byte is registered in the result queue, then offered on o_out;
//   a summary after a payload word from the same byte is offered once that word is popped
// throughput: one byte per cycle; i_in.ready falls while three or more words wait,
//   set by the four-entry result queue and the output side draining it
// reset: synchronous, clears the parser to expect a first header byte and empties the queue
`timescale 1ns / 1ps

module websocket_frame_header_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wsfhp_in_if.sink    i_in,
    wsfhp_out_if.source o_out
);
    import wsfhp_pkg::*;

    t_push   w_push;
    t_result w_res0;
    t_result w_res1;
    t_result w_res;
    logic    w_space;
    logic    w_accept;

    // byte handshake
    assign i_in.ready = w_space;
    assign w_accept   = i_in.valid && w_space;

    wsfhp_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_data_byte (i_in.data_byte),
        .i_last_byte (i_in.last_byte),
        .o_push      (w_push),
        .o_res0      (w_res0),
        .o_res1      (w_res1)
    );

    wsfhp_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_res0  (w_res0),
        .i_res1  (w_res1),
        .i_pop   (o_out.ready),
        .o_space (w_space),
        .o_valid (o_out.valid),
        .o_res   (w_res)
    );

    // result word fields
    assign o_out.kind         = w_res.kind;
    assign o_out.payload_byte = w_res.payload_byte;
    assign o_out.status       = w_res.status;
    assign o_out.fin          = w_res.fin;
    assign o_out.opcode       = w_res.opcode;
    assign o_out.masked       = w_res.masked;
    assign o_out.data_len     = w_res.data_len;
    assign o_out.mask_key     = w_res.mask_key;
    assign o_out.header_len   = w_res.header_len;
    assign o_out.total_len    = w_res.total_len;

endmodule

// ===== design/wsfhp_parse.sv =====
// frame header state and per-byte result generation
`timescale 1ns / 1ps
`include "websocket_frame_header_parser_top_defines.svh"

module wsfhp_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    output wsfhp_pkg::t_push   o_push,
    output wsfhp_pkg::t_result o_res0,
    output wsfhp_pkg::t_result o_res1
);
    import wsfhp_pkg::*;

    t_phase      r_phase, n_phase;
    logic [32:0] r_count, n_count;
    logic [7:0]  r_first, n_first;
    logic        r_mask, n_mask;
    logic [31:0] r_len, n_len;
    logic        r_len_hi, n_len_hi;
    logic [31:0] r_key, n_key;
    logic [3:0]  r_hdr, n_hdr;

    logic [32:0] w_pos_next;
    logic [32:0] w_ext_end;
    logic [32:0] w_pay_end;
    logic [6:0]  w_len7;
    logic [3:0]  w_ext;
    logic        w_payload;
    logic        w_hdr_done;
    logic        w_len_done;
    t_status     w_status;
    t_result     w_summary;
    t_result     w_pay_res;

    // byte positions that close the length field and the payload
    assign w_pos_next = r_count + 33'd1;
    assign w_ext_end  = {29'd0, r_hdr - (r_mask ? KEY_BYTES : 4'd0)};
    assign w_pay_end  = {29'd0, r_hdr} + {1'b0, r_len};
    assign w_len7     = i_data_byte[6:0];

    // next state for the accepted byte
    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_first   = r_first;
        n_mask    = r_mask;
        n_len     = r_len;
        n_len_hi  = r_len_hi;
        n_key     = r_key;
        n_hdr     = r_hdr;
        w_ext     = 4'd0;
        w_payload = 1'b0;

        if (r_phase != PH_DONE) begin
            n_count = w_pos_next;
        end

        case (r_phase)
            PH_HDR0: begin
                n_first = i_data_byte;
                n_phase = PH_HDR1;
            end
            PH_HDR1: begin
                n_mask   = i_data_byte[7];
                n_len_hi = 1'b0;
                if (w_len7 == LEN_EXT16) begin
                    w_ext = EXT16_BYTES;
                    n_len = 32'd0;
                end else if (w_len7 == LEN_EXT64) begin
                    w_ext = EXT64_BYTES;
                    n_len = 32'd0;
                end else begin
                    n_len = {25'd0, w_len7};
                end
                n_hdr = HDR_BASE + w_ext + (i_data_byte[7] ? KEY_BYTES : 4'd0);
                if (w_ext != 4'd0) begin
                    n_phase = PH_EXTLEN;
                end else if (i_data_byte[7]) begin
                    n_phase = PH_KEY;
                end else if (w_len7 == 7'd0) begin
                    n_phase = PH_DONE;
                end else begin
                    n_phase = PH_PAYLOAD;
                end
            end
            PH_EXTLEN: begin
                n_len    = {r_len[23:0], i_data_byte};
                n_len_hi = r_len_hi | (r_len[31:24] != 8'd0);
                if (w_pos_next == w_ext_end) begin
                    if (r_mask) begin
                        n_phase = PH_KEY;
                    end else if (n_len_hi || n_len == 32'd0) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_KEY: begin
                n_key = {r_key[23:0], i_data_byte};
                if (w_pos_next == {29'd0, r_hdr}) begin
                    if (r_len_hi || r_len == 32'd0) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                w_payload = 1'b1;
                if (w_pos_next == w_pay_end) begin
                    n_phase = PH_DONE;
                end
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase
    end

    // summary built from the state after this byte
    assign w_hdr_done = (n_phase == PH_PAYLOAD) || (n_phase == PH_DONE);
    assign w_len_done = w_hdr_done || (n_phase == PH_KEY);

    always_comb begin
        if (!w_hdr_done) begin
            w_status = ST_SHORT;
        end else if (n_len_hi) begin
            w_status = ST_LEN_WIDE;
        end else if (n_phase == PH_PAYLOAD) begin
            w_status = ST_SHORT;
        end else begin
            w_status = ST_COMPLETE;
        end
    end

    always_comb begin
        w_summary              = '0;
        w_summary.kind         = KIND_SUMMARY;
        w_summary.status       = w_status;
        w_summary.fin          = n_first[7];
        w_summary.opcode       = n_first[3:0];
        w_summary.masked       = n_mask;
        w_summary.data_len     = w_len_done ? n_len : 32'd0;
        w_summary.mask_key     = (w_hdr_done && n_mask) ? n_key : 32'd0;
        w_summary.header_len   = (n_phase == PH_HDR0 || n_phase == PH_HDR1) ? HDR_BASE : n_hdr;
        w_summary.total_len    = (w_status == ST_COMPLETE)
                               ? ({29'd0, n_hdr} + {1'b0, n_len}) : 33'd0;

        w_pay_res              = '0;
        w_pay_res.kind         = KIND_PAYLOAD;
        w_pay_res.payload_byte = i_data_byte;
    end

    // payload word goes ahead of the summary
    assign o_push.push_one = i_accept && (w_payload || i_last_byte);
    assign o_push.push_two = i_accept && w_payload && i_last_byte;
    assign o_res0          = w_payload ? w_pay_res : w_summary;
    assign o_res1          = w_summary;

    // parser state, cleared at reset and after each buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last_byte)) begin
            r_phase  <= PH_HDR0;
            r_count  <= 33'd0;
            r_first  <= 8'd0;
            r_mask   <= 1'b0;
            r_len    <= 32'd0;
            r_len_hi <= 1'b0;
            r_key    <= 32'd0;
            r_hdr    <= 4'd0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_first  <= n_first;
            r_mask   <= n_mask;
            r_len    <= n_len;
            r_len_hi <= n_len_hi;
            r_key    <= n_key;
            r_hdr    <= n_hdr;
        end
    end

    `WSFHP_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, i_accept && i_last_byte, r_phase == PH_HDR0 && r_count == 33'd0)
    `WSFHP_ASSERT_IMPL(a_hdr_range, i_clk, i_rst_n, 1'b1, r_hdr <= HDR_MAX)
    `WSFHP_ASSERT_NEXT(a_done_holds, i_clk, i_rst_n, r_phase == PH_DONE && !(i_accept && i_last_byte), r_phase == PH_DONE && $stable(r_count))

endmodule

// ===== design/wsfhp_outq.sv =====
// small result queue taking up to two words per cycle
`timescale 1ns / 1ps
`include "websocket_frame_header_parser_top_defines.svh"

module wsfhp_outq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  wsfhp_pkg::t_push   i_push,
    input  wsfhp_pkg::t_result i_res0,
    input  wsfhp_pkg::t_result i_res1,
    input  logic               i_pop,
    output logic               o_space,
    output logic               o_valid,
    output wsfhp_pkg::t_result o_res
);
    import wsfhp_pkg::*;

    localparam logic [QUEUE_AW:0] SPACE_LIMIT = (QUEUE_AW + 1)'(QUEUE_DEPTH - 2);

    t_result             r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_AW:0]   r_count, n_count;
    logic [QUEUE_AW:0]   w_push_cnt;
    logic                w_pop;

    // room for a byte that makes two words
    assign o_space = (r_count <= SPACE_LIMIT);
    assign o_valid = (r_count != '0);
    assign o_res   = r_mem[r_rd_ptr];
    assign w_pop   = o_valid && i_pop;

    assign w_push_cnt = {{QUEUE_AW{1'b0}}, i_push.push_one}
                      + {{QUEUE_AW{1'b0}}, i_push.push_two};

    // pointer and fill updates
    always_comb begin
        n_wr_ptr = r_wr_ptr + w_push_cnt[QUEUE_AW-1:0];
        n_rd_ptr = r_rd_ptr + {{(QUEUE_AW-1){1'b0}}, w_pop};
        n_count  = r_count + w_push_cnt - {{QUEUE_AW{1'b0}}, w_pop};
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push.push_one) begin
            r_mem[r_wr_ptr] <= i_res0;
        end
        if (i_push.push_two) begin
            r_mem[r_wr_ptr + {{(QUEUE_AW-1){1'b0}}, 1'b1}] <= i_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    `WSFHP_ASSERT_IMPL(a_push_has_room, i_clk, i_rst_n, i_push.push_one, r_count <= SPACE_LIMIT)
    `WSFHP_ASSERT_IMPL(a_two_implies_one, i_clk, i_rst_n, i_push.push_two, i_push.push_one)
    `WSFHP_ASSERT_NEXT(a_pop_drains, i_clk, i_rst_n, w_pop && !i_push.push_one, r_count == $past(r_count) - 1'b1)

endmodule

// ===== bench/websocket_frame_header_parser_top_test.sv =====
// self-checking bench for the websocket frame header parser with random byte streams
`timescale 1ns / 1ps

module websocket_frame_header_parser_top_test;
    import wsfhp_pkg::*;

    localparam int STREAM_BYTES  = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_AT_BYTE  = 600;
    localparam int STEADY_FROM   = 1300;
    localparam int STEADY_TO     = 1600;
    localparam int IDLE_PERCENT  = 32;
    localparam int STUCK_LIMIT   = 2000;
    localparam int TAIL_CYCLES   = 20;
    localparam int MAX_REPORTS   = 10;
    localparam int MAX_PAYLOAD   = 40;

    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         drain;
    } rx_byte_t;

    logic i_clk;
    logic i_rst_n;

    wsfhp_in_if  in_bus ();
    wsfhp_out_if out_bus ();

    websocket_frame_header_parser_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // stimulus and scoreboard storage
    rx_byte_t    rx_stream[$];
    logic [7:0]  rx_buf[$];
    t_result     frame_words_due[$];
    bit          byte_taken;
    bit          send_free;
    int          bytes_accepted;
    int          fail_count;
    int          stuck_cycles;
    int          hold_left;
    bit          hold_done;

    // parser shadow state
    t_phase      ps_phase;
    logic [32:0] ps_count;
    logic [7:0]  ps_hdr0;
    logic        ps_mask;
    logic [63:0] ps_len;
    logic [31:0] ps_key;
    logic [3:0]  ps_hdr_len;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic clear_parse();
        ps_phase   = PH_HDR0;
        ps_count   = '0;
        ps_hdr0    = '0;
        ps_mask    = 1'b0;
        ps_len     = '0;
        ps_key     = '0;
        ps_hdr_len = '0;
    endtask

    // zero length or a length past 32 bits ends the frame with its header
    task automatic enter_payload();
        if (ps_len[63:32] != 32'd0 || ps_len == 64'd0) begin
            ps_phase = PH_DONE;
        end else begin
            ps_phase = PH_PAYLOAD;
        end
    endtask

    task automatic length_complete();
        if (ps_mask) begin
            ps_phase = PH_KEY;
        end else begin
            enter_payload();
        end
    endtask

    // advance the shadow parser by one byte and queue the words it produces
    task automatic parse_rx_byte(input logic [7:0] b, input logic last);
        logic [32:0] pos;
        logic [3:0]  ext;
        logic        hdr_done;
        logic        len_done;
        t_result     w;
        pos = ps_count;
        if (ps_phase <= PH_PAYLOAD) ps_count = ps_count + 33'd1;
        case (ps_phase)
            PH_HDR0: begin
                ps_hdr0  = b;
                ps_phase = PH_HDR1;
            end
            PH_HDR1: begin
                ps_mask = b[7];
                ext     = 4'd0;
                ps_len  = {57'd0, b[6:0]};
                if (b[6:0] == LEN_EXT16) begin
                    ext    = EXT16_BYTES;
                    ps_len = '0;
                end else if (b[6:0] == LEN_EXT64) begin
                    ext    = EXT64_BYTES;
                    ps_len = '0;
                end
                ps_hdr_len = HDR_BASE + ext + (ps_mask ? KEY_BYTES : 4'd0);
                if (ext != 4'd0) begin
                    ps_phase = PH_EXTLEN;
                end else begin
                    length_complete();
                end
            end
            PH_EXTLEN: begin
                ps_len = {ps_len[55:0], b};
                if (pos + 33'd1 == {29'd0, ps_hdr_len - (ps_mask ? KEY_BYTES : 4'd0)})
                    length_complete();
            end
            PH_KEY: begin
                ps_key = {ps_key[23:0], b};
                if (pos + 33'd1 == {29'd0, ps_hdr_len}) enter_payload();
            end
            PH_PAYLOAD: begin
                w              = '0;
                w.kind         = KIND_PAYLOAD;
                w.payload_byte = b;
                frame_words_due.push_back(w);
                if ({31'd0, pos} + 64'd1 == {60'd0, ps_hdr_len} + ps_len) ps_phase = PH_DONE;
            end
            default: ps_phase = PH_DONE;
        endcase

        // end of buffer: summary word, then back to the first header byte
        if (last) begin
            hdr_done = (ps_phase >= PH_PAYLOAD);
            len_done = (ps_phase >= PH_KEY);
            w        = '0;
            w.kind   = KIND_SUMMARY;
            if (!hdr_done) begin
                w.status = ST_SHORT;
            end else if (ps_len[63:32] != 32'd0) begin
                w.status = ST_LEN_WIDE;
            end else if (ps_phase == PH_PAYLOAD) begin
                w.status = ST_SHORT;
            end else begin
                w.status = ST_COMPLETE;
            end
            w.fin        = ps_hdr0[7];
            w.opcode     = ps_hdr0[3:0];
            w.masked     = ps_mask;
            w.data_len   = len_done ? ps_len[31:0] : 32'd0;
            w.mask_key   = (hdr_done && ps_mask) ? ps_key : 32'd0;
            w.header_len = (ps_phase >= PH_EXTLEN) ? ps_hdr_len : HDR_BASE;
            w.total_len  = (w.status == ST_COMPLETE) ? {29'd0, ps_hdr_len} + ps_len[32:0] : '0;
            frame_words_due.push_back(w);
            clear_parse();
        end
    endtask

    function automatic string show_word(input t_result w);
        return $sformatf("kind=%0d byte=%02h st=%0d fin=%0d op=%0h mask=%0d plen=%08h key=%08h hlen=%0d flen=%09h",
                         w.kind, w.payload_byte, w.status, w.fin, w.opcode, w.masked,
                         w.data_len, w.mask_key, w.header_len, w.total_len);
    endfunction

    // compare one output word against the oldest expected word
    task automatic check_word(input t_result got);
        t_result want;
        if (frame_words_due.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) $display("unexpected word: %s", show_word(got));
        end else begin
            want = frame_words_due.pop_front();
            if (got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
                got.status !== want.status || got.fin !== want.fin ||
                got.opcode !== want.opcode || got.masked !== want.masked ||
                got.data_len !== want.data_len || got.mask_key !== want.mask_key ||
                got.header_len !== want.header_len || got.total_len !== want.total_len) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS) begin
                    $display("mismatch at %0t", $realtime);
                    $display("  expected %s", show_word(want));
                    $display("  actual   %s", show_word(got));
                end
            end
        end
    endtask

    // move the scratch buffer into the stream, last flag on its final byte
    task automatic flush_buffer(input bit drain);
        rx_byte_t item;
        for (int i = 0; i < rx_buf.size(); i++) begin
            item.data  = rx_buf[i];
            item.last  = (i == rx_buf.size() - 1);
            item.drain = drain && (i == 0);
            rx_stream.push_back(item);
        end
        rx_buf.delete();
    endtask

    // one receive buffer: mostly well-formed frames, some noise, cut or padded
    task automatic add_random_buffer(input bit drain);
        int unsigned pick;
        int unsigned n;
        logic [63:0] len64;
        logic        mask_b;
        pick = $urandom_range(99);
        if (pick < 10) begin
            n = $urandom_range(1, 12);
            repeat (n) rx_buf.push_back(8'($urandom_range(255)));
        end else begin
            mask_b = 1'($urandom_range(1));
            len64  = ($urandom_range(9) == 0) ? 64'd0 : 64'($urandom_range(1, 30));
            rx_buf.push_back(8'($urandom_range(255)));
            case ($urandom_range(2))
                0: begin
                    if ($urandom_range(5) == 0) len64 = 64'($urandom_range(125));
                    rx_buf.push_back({mask_b, len64[6:0]});
                end
                1: begin
                    if ($urandom_range(7) == 0) len64 = 64'($urandom_range(65535));
                    rx_buf.push_back({mask_b, LEN_EXT16});
                    rx_buf.push_back(len64[15:8]);
                    rx_buf.push_back(len64[7:0]);
                end
                default: begin
                    pick = $urandom_range(9);
                    if (pick == 0) begin
                        len64[63:32] = $urandom;
                        if (len64[63:32] == 32'd0) len64[63:32] = 32'd1;
                    end else if (pick == 1) begin
                        len64[31:0] = $urandom;
                    end
                    rx_buf.push_back({mask_b, LEN_EXT64});
                    for (int i = 7; i >= 0; i--) rx_buf.push_back(len64[i*8 +: 8]);
                end
            endcase
            if (mask_b) repeat (4) rx_buf.push_back(8'($urandom_range(255)));
            n = (len64 > 64'(MAX_PAYLOAD)) ? MAX_PAYLOAD : int'(len64[5:0]);
            repeat (n) rx_buf.push_back(8'($urandom_range(255)));
            // bytes past the frame end
            if ($urandom_range(4) == 0) begin
                n = $urandom_range(1, 4);
                repeat (n) rx_buf.push_back(8'($urandom_range(255)));
            end
            // buffer cut short
            if ($urandom_range(6) == 0) begin
                n = $urandom_range(1, rx_buf.size());
                while (rx_buf.size() > n) void'(rx_buf.pop_back());
            end
        end
        flush_buffer(drain);
    endtask

    function automatic bit in_steady_stretch();
        return bytes_accepted >= STEADY_FROM && bytes_accepted < STEADY_TO;
    endfunction

    // stimulus build, reset and end of run
    initial begin
        bit midway_drained;
        in_bus.valid     = 1'b0;
        in_bus.data_byte = 8'd0;
        in_bus.last_byte = 1'b0;
        out_bus.ready    = 1'b0;
        i_rst_n          = 1'b0;
        byte_taken       = 1'b0;
        send_free        = 1'b0;
        bytes_accepted   = 0;
        fail_count       = 0;
        stuck_cycles     = 0;
        hold_left        = 0;
        hold_done        = 1'b0;
        midway_drained   = 1'b0;
        clear_parse();

        // buffer ends on the first header byte
        rx_buf = '{8'hFF};
        flush_buffer(1'b0);
        // empty unmasked frame
        rx_buf = '{8'h00, 8'h00};
        flush_buffer(1'b0);
        // masked frame with one payload byte
        rx_buf = '{8'h81, 8'h81, 8'h12, 8'h34, 8'h56, 8'h78, 8'hAB};
        flush_buffer(1'b0);
        // 16-bit length, payload cut short
        rx_buf = '{8'h82, 8'h7E, 8'h00, 8'h02, 8'hCD};
        flush_buffer(1'b0);
        // 64-bit length with high bytes set
        rx_buf = '{8'h0A, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h01, 8'hDE, 8'hAD, 8'hBE, 8'hEF};
        flush_buffer(1'b0);
        // ends inside the widest header
        rx_buf = '{8'h7F, 8'hFF};
        flush_buffer(1'b0);

        add_random_buffer(1'b1);
        while (rx_stream.size() < STREAM_BYTES) begin
            add_random_buffer(!midway_drained && rx_stream.size() >= STREAM_BYTES / 2);
            if (rx_stream.size() >= STREAM_BYTES / 2) midway_drained = 1'b1;
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (rx_stream.size() != 0 || frame_words_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // byte acceptance feeds the shadow parser
    always @(posedge i_clk) begin
        if (i_rst_n && in_bus.valid && in_bus.ready) begin
            parse_rx_byte(in_bus.data_byte, in_bus.last_byte);
            bytes_accepted++;
            byte_taken = 1'b1;
        end
    end

    // byte driver, holds a word until it is taken, may idle once it is
    always @(negedge i_clk) begin
        send_free = !in_bus.valid || byte_taken;
        if (byte_taken) begin
            void'(rx_stream.pop_front());
            byte_taken = 1'b0;
        end
        if (!i_rst_n || rx_stream.size() == 0) begin
            in_bus.valid <= 1'b0;
        end else if (send_free && rx_stream[0].drain && frame_words_due.size() != 0) begin
            in_bus.valid <= 1'b0;
        end else if (send_free && !in_steady_stretch() && $urandom_range(99) < IDLE_PERCENT) begin
            in_bus.valid <= 1'b0;
        end else begin
            in_bus.valid     <= 1'b1;
            in_bus.data_byte <= rx_stream[0].data;
            in_bus.last_byte <= rx_stream[0].last;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            check_word({out_bus.kind, out_bus.payload_byte, out_bus.status, out_bus.fin,
                        out_bus.opcode, out_bus.masked, out_bus.data_len,
                        out_bus.mask_key, out_bus.header_len, out_bus.total_len});
        end
    end

    // result ready, with one long hold-off to back the parser up
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            out_bus.ready <= 1'b0;
        end else if (!hold_done && bytes_accepted >= HOLD_AT_BYTE) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            out_bus.ready <= 1'b0;
        end else begin
            out_bus.ready <= in_steady_stretch() || $urandom_range(99) >= IDLE_PERCENT;
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
                if (stuck_cycles >= STUCK_LIMIT) begin
                    $display("watchdog: no word moved for %0d cycles", STUCK_LIMIT);
                    $display("RESULT: ERROR");
                    $finish;
                end
            end
        end
    end

endmodule

// ===== sim.f =====
+incdir+design
design/wsfhp_pkg.sv
design/wsfhp_if.sv
design/wsfhp_parse.sv
design/wsfhp_outq.sv
design/websocket_frame_header_parser_top.sv
bench/websocket_frame_header_parser_top_test.sv
